// File: rtl/dxt_pkg.sv
package dxt_pkg;

   localparam int CSR_DATA_W = 13;
   localparam int CSR_INDEX_W = 2;
   localparam int DEF_MAX_IMAGE_DIM = 4096;
   localparam logic [CSR_DATA_W-1:0] RESET_IMAGE_DIM = 13'd4096;

   localparam int REQ_DATA_W = 152;
   localparam int RSP_DATA_W = 56;

   localparam logic [1:0] FMT_DXT1 = 2'd0;
   localparam logic [1:0] FMT_DXT3 = 2'd1;

   localparam logic [CSR_INDEX_W-1:0] CSR_BLOCK_FORMAT = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_WIDTH  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_HEIGHT = 2'd2;

   // Reciprocals for the fixed divisors; each is exact over the value range it serves.
   localparam logic [15:0] RECIP_31 = 16'd33826;  // 2^20 scale
   localparam logic [14:0] RECIP_63 = 15'd16645;  // 2^20 scale
   localparam logic [9:0]  RECIP_3  = 10'd683;    // 2^11 scale
   localparam logic [11:0] RECIP_5  = 12'd3277;   // 2^14 scale
   localparam logic [11:0] RECIP_7  = 12'd2341;   // 2^14 scale

   function automatic logic [7:0] expand5(input logic [4:0] c);
      logic [12:0] scaled;
      logic [28:0] prod;
      scaled = 13'(c) * 13'd255;
      prod = 29'(scaled) * 29'(RECIP_31);
      return prod[27:20];
   endfunction

   function automatic logic [7:0] expand6(input logic [5:0] c);
      logic [13:0] scaled;
      logic [28:0] prod;
      scaled = 14'(c) * 14'd255;
      prod = 29'(scaled) * 29'(RECIP_63);
      return prod[27:20];
   endfunction

   function automatic logic [7:0] div3(input logic [9:0] x);
      logic [19:0] prod;
      prod = 20'(x) * 20'(RECIP_3);
      return prod[18:11];
   endfunction

   function automatic logic [7:0] div5(input logic [10:0] x);
      logic [22:0] prod;
      prod = 23'(x) * 23'(RECIP_5);
      return prod[21:14];
   endfunction

   function automatic logic [7:0] div7(input logic [10:0] x);
      logic [22:0] prod;
      prod = 23'(x) * 23'(RECIP_7);
      return prod[21:14];
   endfunction

endpackage

// File: rtl/dxt_block_texel_decoder.sv
// Channel  | Direction | Beat contents
// req      | in        | tdata: block_col, block_row, alpha_half, color_half
// rsp      | out       | tdata: texel_x, texel_y, blue, green, red, alpha; tlast: last_texel
// csr      | in        | write enable, register index, write data
//
// A block beat emits one texel beat per cycle while rsp is not stalled, up to
// 16 texels per block, as many as lie inside the image.  A block with
// no texel inside the image is dropped in its accept cycle.  The next block is
// taken in the cycle its predecessor's last texel moves to the output register,
// so blocks follow without gaps.  Reset is synchronous and clears all control
// state and the configuration registers.  A stalled rsp holds the texel in
// place and stops the texel walk.
module dxt_block_texel_decoder
   import dxt_pkg::*;
#(
   parameter int MAX_IMAGE_DIM = DEF_MAX_IMAGE_DIM
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // block_col[9:0], block_row[19:10], alpha_half[83:20], color_half[147:84], zeros
   input  logic [REQ_DATA_W-1:0]  req_tdata,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // texel_x[11:0], texel_y[23:12], blue[31:24], green[39:32], red[47:40], alpha[55:48]
   output logic [RSP_DATA_W-1:0]  rsp_tdata,
   output logic                   rsp_tlast,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int DIM_W = $clog2(MAX_IMAGE_DIM + 1);
   localparam int CMP_W = (DIM_W > CSR_DATA_W) ? DIM_W : CSR_DATA_W;
   localparam logic [CMP_W-1:0] DIM_LIMIT = CMP_W'(MAX_IMAGE_DIM);

   // Configuration
   logic [1:0]            fmt_ff;
   logic [CSR_DATA_W-1:0] width_ff;
   logic [CSR_DATA_W-1:0] height_ff;

   // Block held while its texels are walked
   logic        hold_valid_ff, hold_valid_in;
   logic [9:0]  hold_bx_ff, hold_by_ff;
   logic [63:0] hold_alpha_ff, hold_color_ff;
   logic [7:0]  hold_r0_ff, hold_g0_ff, hold_b0_ff;
   logic [7:0]  hold_r1_ff, hold_g1_ff, hold_b1_ff;
   logic [2:0]  ncol_ff, nrow_ff;
   logic [1:0]  col_ff, col_in, row_ff, row_in;

   // Output register
   logic        rsp_valid_ff, rsp_valid_in;
   logic [11:0] rsp_x_ff, rsp_y_ff;
   logic [7:0]  rsp_b_ff, rsp_g_ff, rsp_r_ff, rsp_a_ff;
   logic        rsp_last_ff;

   logic        req_fire, advance, at_last;
   logic [9:0]  req_bx, req_by;
   logic [63:0] req_alpha, req_color;
   logic [CMP_W-1:0] w_eff, h_eff, base_x, base_y, diff_x, diff_y;
   logic [2:0]  req_ncol, req_nrow;

   logic [7:0]  pr [4];
   logic [7:0]  pg [4];
   logic [7:0]  pb [4];
   logic [7:0]  pa [4];
   logic [7:0]  apal [8];
   logic [7:0]  a0, a1;
   logic        three_color;
   logic [3:0]  p;
   logic [31:0] color_idx;
   logic [47:0] alpha_idx;
   logic [1:0]  ci;
   logic [3:0]  nib;
   logic [2:0]  ai;
   logic [7:0]  av;

   assign req_bx    = req_tdata[9:0];
   assign req_by    = req_tdata[19:10];
   assign req_alpha = req_tdata[83:20];
   assign req_color = req_tdata[147:84];

   // Texels in the block that fall inside the image form a rectangle of
   // req_ncol columns by req_nrow rows from the block's upper left corner.
   always_comb begin
      w_eff  = (CMP_W'(width_ff) > DIM_LIMIT) ? DIM_LIMIT : CMP_W'(width_ff);
      h_eff  = (CMP_W'(height_ff) > DIM_LIMIT) ? DIM_LIMIT : CMP_W'(height_ff);
      base_x = CMP_W'({req_bx, 2'b00});
      base_y = CMP_W'({req_by, 2'b00});
      diff_x = w_eff - base_x;
      diff_y = h_eff - base_y;
      if (w_eff <= base_x) begin
         req_ncol = 3'd0;
      end else if (diff_x >= CMP_W'(4)) begin
         req_ncol = 3'd4;
      end else begin
         req_ncol = diff_x[2:0];
      end
      if (h_eff <= base_y) begin
         req_nrow = 3'd0;
      end else if (diff_y >= CMP_W'(4)) begin
         req_nrow = 3'd4;
      end else begin
         req_nrow = diff_y[2:0];
      end
   end

   assign at_last    = ({1'b0, col_ff} == ncol_ff - 3'd1) && ({1'b0, row_ff} == nrow_ff - 3'd1);
   assign advance    = hold_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !hold_valid_ff || (advance && at_last);
   assign req_fire   = req_tvalid && req_tready;

   // Palettes from the held block
   always_comb begin
      three_color = (fmt_ff == FMT_DXT1) && !(hold_color_ff[15:0] > hold_color_ff[31:16]);
      pr[0] = hold_r0_ff;  pg[0] = hold_g0_ff;  pb[0] = hold_b0_ff;  pa[0] = 8'd255;
      pr[1] = hold_r1_ff;  pg[1] = hold_g1_ff;  pb[1] = hold_b1_ff;  pa[1] = 8'd255;
      pa[2] = 8'd255;
      if (three_color) begin
         pr[2] = 8'((9'(hold_r0_ff) + 9'(hold_r1_ff)) >> 1);
         pg[2] = 8'((9'(hold_g0_ff) + 9'(hold_g1_ff)) >> 1);
         pb[2] = 8'((9'(hold_b0_ff) + 9'(hold_b1_ff)) >> 1);
         pr[3] = 8'd0;
         pg[3] = 8'd0;
         pb[3] = 8'd0;
         pa[3] = 8'd0;
      end else begin
         pr[2] = div3({1'b0, hold_r0_ff, 1'b0} + 10'(hold_r1_ff));
         pg[2] = div3({1'b0, hold_g0_ff, 1'b0} + 10'(hold_g1_ff));
         pb[2] = div3({1'b0, hold_b0_ff, 1'b0} + 10'(hold_b1_ff));
         pr[3] = div3(10'(hold_r0_ff) + {1'b0, hold_r1_ff, 1'b0});
         pg[3] = div3(10'(hold_g0_ff) + {1'b0, hold_g1_ff, 1'b0});
         pb[3] = div3(10'(hold_b0_ff) + {1'b0, hold_b1_ff, 1'b0});
         pa[3] = 8'd255;
      end

      a0 = hold_alpha_ff[7:0];
      a1 = hold_alpha_ff[15:8];
      apal[0] = a0;
      apal[1] = a1;
      if (a0 > a1) begin
         for (int k = 1; k <= 6; k++) begin
            apal[k+1] = div7(11'(a0) * 11'(7 - k) + 11'(a1) * 11'(k));
         end
      end else begin
         for (int k = 1; k <= 4; k++) begin
            apal[k+1] = div5(11'(a0) * 11'(5 - k) + 11'(a1) * 11'(k));
         end
         apal[6] = 8'd0;
         apal[7] = 8'd255;
      end
   end

   // Current texel
   always_comb begin
      p         = {row_ff, col_ff};
      color_idx = hold_color_ff[63:32];
      alpha_idx = hold_alpha_ff[63:16];
      ci        = color_idx[{p, 1'b0} +: 2];
      nib       = hold_alpha_ff[{p, 2'b00} +: 4];
      ai        = alpha_idx[6'(p) * 6'd3 +: 3];
      case (fmt_ff)
         FMT_DXT1: av = pa[ci];
         FMT_DXT3: av = {nib, nib};
         default:  av = apal[ai];
      endcase
   end

   always_comb begin
      hold_valid_in = hold_valid_ff;
      col_in        = col_ff;
      row_in        = row_ff;
      rsp_valid_in  = rsp_valid_ff;
      if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (advance) begin
         rsp_valid_in = 1'b1;
         if (at_last) begin
            hold_valid_in = 1'b0;
         end else if ({1'b0, col_ff} == ncol_ff - 3'd1) begin
            col_in = 2'd0;
            row_in = row_ff + 2'd1;
         end else begin
            col_in = col_ff + 2'd1;
         end
      end
      if (req_fire) begin
         hold_valid_in = (req_ncol != 3'd0) && (req_nrow != 3'd0);
         col_in        = 2'd0;
         row_in        = 2'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fmt_ff        <= FMT_DXT1;
         width_ff      <= RESET_IMAGE_DIM;
         height_ff     <= RESET_IMAGE_DIM;
         hold_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         col_ff        <= 2'd0;
         row_ff        <= 2'd0;
      end else begin
         hold_valid_ff <= hold_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         col_ff        <= col_in;
         row_ff        <= row_in;
         if (csr_we) begin
            case (csr_index)
               CSR_BLOCK_FORMAT: fmt_ff    <= csr_wdata[1:0];
               CSR_IMAGE_WIDTH:  width_ff  <= csr_wdata;
               CSR_IMAGE_HEIGHT: height_ff <= csr_wdata;
               default: ;
            endcase
         end
      end
      if (req_fire) begin
         hold_bx_ff    <= req_bx;
         hold_by_ff    <= req_by;
         hold_alpha_ff <= req_alpha;
         hold_color_ff <= req_color;
         hold_r0_ff    <= expand5(req_color[15:11]);
         hold_g0_ff    <= expand6(req_color[10:5]);
         hold_b0_ff    <= expand5(req_color[4:0]);
         hold_r1_ff    <= expand5(req_color[31:27]);
         hold_g1_ff    <= expand6(req_color[26:21]);
         hold_b1_ff    <= expand5(req_color[20:16]);
         ncol_ff       <= req_ncol;
         nrow_ff       <= req_nrow;
      end
      if (advance) begin
         rsp_x_ff    <= {hold_bx_ff, col_ff};
         rsp_y_ff    <= {hold_by_ff, row_ff};
         rsp_b_ff    <= pb[ci];
         rsp_g_ff    <= pg[ci];
         rsp_r_ff    <= pr[ci];
         rsp_a_ff    <= av;
         rsp_last_ff <= at_last;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_a_ff, rsp_r_ff, rsp_g_ff, rsp_b_ff, rsp_y_ff, rsp_x_ff};
   assign rsp_tlast  = rsp_last_ff;

   // A held block always has at least one texel inside the image.
   a_hold_nonempty: assert property (@(posedge clock) disable iff (reset)
      hold_valid_ff |-> (ncol_ff != 3'd0) && (nrow_ff != 3'd0))
      else $error("held block has an empty texel rectangle");

   // The texel walk stays inside the block's rectangle.
   a_walk_in_range: assert property (@(posedge clock) disable iff (reset)
      hold_valid_ff |-> ({1'b0, col_ff} < ncol_ff) && ({1'b0, row_ff} < nrow_ff))
      else $error("texel walk left the visible rectangle");

   // Finishing a block with no new block arriving empties the hold stage.
   a_release: assert property (@(posedge clock) disable iff (reset)
      advance && at_last && !req_fire |=> !hold_valid_ff)
      else $error("hold stage not released after last texel");

   // A new texel beat only appears after a held block fed the output register.
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(hold_valid_ff))
      else $error("texel beat without a held block");

endmodule

// File: sim/tb.sv
module tb;
   import dxt_pkg::*;

   localparam logic [1:0] FMT_DXT5 = 2'd2;
   // Code three falls to the default, interpolated-alpha branch of the format case, so it decodes as DXT5.
   localparam logic [1:0] FMT_DXT5_ALIAS = 2'd3;
   localparam int DRAIN_CYCLES = 32;

   typedef struct packed {
      logic [11:0] x;
      logic [11:0] y;
      logic [7:0]  b;
      logic [7:0]  g;
      logic [7:0]  r;
      logic [7:0]  a;
      logic        last;
   } texel_type;

   class texel_scoreboard;
      logic [1:0]            fmt = FMT_DXT1;
      logic [CSR_DATA_W-1:0] width = RESET_IMAGE_DIM;
      logic [CSR_DATA_W-1:0] height = RESET_IMAGE_DIM;
      texel_type pending[$];
      int blocks;
      int texels;
      int errors;

      function void set_register(input logic [CSR_INDEX_W-1:0] idx,
                                 input logic [CSR_DATA_W-1:0] val);
         case (idx)
            CSR_BLOCK_FORMAT: fmt = val[1:0];
            CSR_IMAGE_WIDTH:  width = val;
            CSR_IMAGE_HEIGHT: height = val;
            default: ;
         endcase
      endfunction

      function int clamp_dim(input logic [CSR_DATA_W-1:0] d);
         return (d > DEF_MAX_IMAGE_DIM) ? DEF_MAX_IMAGE_DIM : int'(d);
      endfunction

      function int widen(input int v, input int top);
         return v * 255 / top;
      endfunction

      function void note_block(input logic [REQ_DATA_W-1:0] d);
         int bx, by, w, h, c0, c1, ci, av, a0, a1, k, p, x, y;
         int r[4], g[4], b[4], ca[4], apal[8];
         logic [63:0] ah, ch;
         bit three;
         texel_type t;
         texel_type blk[$];
         bx = int'(d[9:0]);
         by = int'(d[19:10]);
         ah = d[83:20];
         ch = d[147:84];
         w = clamp_dim(width);
         h = clamp_dim(height);
         c0 = int'(ch[15:0]);
         c1 = int'(ch[31:16]);
         r[0] = widen(int'(ch[15:11]), 31);
         g[0] = widen(int'(ch[10:5]), 63);
         b[0] = widen(int'(ch[4:0]), 31);
         r[1] = widen(int'(ch[31:27]), 31);
         g[1] = widen(int'(ch[26:21]), 63);
         b[1] = widen(int'(ch[20:16]), 31);
         ca = '{255, 255, 255, 255};
         three = (fmt == FMT_DXT1) && !(c0 > c1);
         if (three) begin
            r[2] = (r[0] + r[1]) / 2;
            g[2] = (g[0] + g[1]) / 2;
            b[2] = (b[0] + b[1]) / 2;
            r[3] = 0;
            g[3] = 0;
            b[3] = 0;
            ca[3] = 0;
         end else begin
            r[2] = (2 * r[0] + r[1]) / 3;
            g[2] = (2 * g[0] + g[1]) / 3;
            b[2] = (2 * b[0] + b[1]) / 3;
            r[3] = (r[0] + 2 * r[1]) / 3;
            g[3] = (g[0] + 2 * g[1]) / 3;
            b[3] = (b[0] + 2 * b[1]) / 3;
         end
         a0 = int'(ah[7:0]);
         a1 = int'(ah[15:8]);
         apal[0] = a0;
         apal[1] = a1;
         if (a0 > a1) begin
            for (k = 1; k <= 6; k++) apal[k+1] = ((7 - k) * a0 + k * a1) / 7;
         end else begin
            for (k = 1; k <= 4; k++) apal[k+1] = ((5 - k) * a0 + k * a1) / 5;
            apal[6] = 0;
            apal[7] = 255;
         end
         for (p = 0; p < 16; p++) begin
            x = bx * 4 + p % 4;
            y = by * 4 + p / 4;
            if (x >= w || y >= h) continue;
            ci = int'(ch[32 + 2 * p +: 2]);
            if (fmt == FMT_DXT1) av = ca[ci];
            else if (fmt == FMT_DXT3) av = int'(ah[4 * p +: 4]) * 17;
            else av = apal[int'(ah[16 + 3 * p +: 3])];
            t.x = x[11:0];
            t.y = y[11:0];
            t.b = b[ci][7:0];
            t.g = g[ci][7:0];
            t.r = r[ci][7:0];
            t.a = av[7:0];
            t.last = 1'b0;
            blk.push_back(t);
         end
         if (blk.size() > 0) begin
            t = blk.pop_back();
            t.last = 1'b1;
            blk.push_back(t);
         end
         foreach (blk[i]) pending.push_back(blk[i]);
         blocks++;
      endfunction

      function void check_texel(input logic [RSP_DATA_W-1:0] d, input logic last);
         texel_type got, want;
         got.x = d[11:0];
         got.y = d[23:12];
         got.b = d[31:24];
         got.g = d[39:32];
         got.r = d[47:40];
         got.a = d[55:48];
         got.last = last;
         texels++;
         if (pending.size() == 0) begin
            errors++;
            if (errors <= 10)
               $display("texel beat x=%0d y=%0d arrived with no block pending", got.x, got.y);
            return;
         end
         want = pending.pop_front();
         if (got.x !== want.x || got.y !== want.y || got.b !== want.b || got.g !== want.g ||
             got.r !== want.r || got.a !== want.a || got.last !== want.last) begin
            errors++;
            if (errors <= 10) begin
               $display("texel mismatch: expected x=%0d y=%0d bgra=%h %h %h %h last=%b",
                        want.x, want.y, want.b, want.g, want.r, want.a, want.last);
               $display("                got      x=%0d y=%0d bgra=%h %h %h %h last=%b",
                        got.x, got.y, got.b, got.g, got.r, got.a, got.last);
            end
         end
      endfunction
   endclass

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_DATA_W-1:0]  req_tdata = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]  rsp_tdata;
   logic                   rsp_tlast;
   logic                   csr_we = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   int send_idle_pct = 31;
   int recv_idle_pct = 75;
   texel_scoreboard sb;

   dxt_block_texel_decoder u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
   end

   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready) sb.note_block(req_tdata);
      if (!reset && rsp_tvalid && rsp_tready) sb.check_texel(rsp_tdata, rsp_tlast);
   end

   task automatic send_block(input logic [9:0] col, input logic [9:0] row,
                             input logic [63:0] ah, input logic [63:0] ch);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {4'b0, ch, ah, row, col};
      do @(posedge clock); while (!req_tready);
   endtask

   // Blocks that fall outside the image leave no expectation behind, so the drain
   // keeps waiting after the last expected texel before the block counts as idle.
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      sb.set_register(idx, val);
   endtask

   task automatic configure(input logic [1:0] fmt, input logic [CSR_DATA_W-1:0] w,
                            input logic [CSR_DATA_W-1:0] h);
      drain();
      write_reg(CSR_BLOCK_FORMAT, CSR_DATA_W'(fmt));
      write_reg(CSR_IMAGE_WIDTH, w);
      write_reg(CSR_IMAGE_HEIGHT, h);
      csr_we <= 1'b0;
   endtask

   // Coordinates mostly land on or just past the image so that blocks
   // produce texels, with some drawn from the whole range.
   task automatic send_random_block();
      int wb, hb;
      logic [9:0] col, row;
      logic [63:0] ah, ch;
      wb = (sb.clamp_dim(sb.width) + 3) / 4;
      hb = (sb.clamp_dim(sb.height) + 3) / 4;
      if (wb > 1023) wb = 1023;
      if (hb > 1023) hb = 1023;
      col = ($urandom_range(99) < 15) ? 10'($urandom_range(1023)) : 10'($urandom_range(wb));
      row = ($urandom_range(99) < 15) ? 10'($urandom_range(1023)) : 10'($urandom_range(hb));
      ah = {$urandom, $urandom};
      ch = {$urandom, $urandom};
      if ($urandom_range(99) < 15) ch[31:16] = ch[15:0];
      if ($urandom_range(99) < 10) ah[15:8] = ah[7:0];
      send_block(col, row, ah, ch);
   endtask

   task automatic random_phase(input logic [1:0] fmt, input logic [CSR_DATA_W-1:0] w,
                               input logic [CSR_DATA_W-1:0] h, input int count);
      configure(fmt, w, h);
      repeat (count) send_random_block();
   endtask

   initial begin
      sb = new();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Four-color, three-color with transparency, equal endpoints, extremes.
      configure(FMT_DXT1, 13'd4096, 13'd4096);
      send_block(10'd0, 10'd0, '1, {32'hE4E4E4E4, 16'h0000, 16'hFFFF});
      send_block(10'd1023, 10'd1023, '0, {32'hE4E4E4E4, 16'hFFFF, 16'h0000});
      send_block(10'd5, 10'd7, {$urandom, $urandom}, {$urandom, 16'h1234, 16'h1234});
      send_block(10'd0, 10'd1023, '0, '1);
      send_block(10'd1023, 10'd0, '1, '0);

      // Explicit alpha on a small image: partial and fully outside blocks.
      configure(FMT_DXT3, 13'd6, 13'd7);
      send_block(10'd0, 10'd0, 64'hFEDCBA9876543210, {32'hE4E4E4E4, 16'hFFFF, 16'h0000});
      send_block(10'd1, 10'd1, 64'h0123456789ABCDEF, {32'h1B1B1B1B, 16'h07E0, 16'hF800});
      send_block(10'd2, 10'd0, '1, '1);
      send_block(10'd0, 10'd2, '1, '1);
      send_block(10'd1, 10'd0, '1, {$urandom, $urandom});

      // Interpolated alpha: six-step, four-step and equal endpoints.
      configure(FMT_DXT5, 13'd4096, 13'd4096);
      send_block(10'd3, 10'd4, 64'hFAC688FAC68800FF, {$urandom, $urandom});
      send_block(10'd3, 10'd4, 64'hFAC688FAC688FF00, {$urandom, $urandom});
      send_block(10'd3, 10'd4, 64'hFAC688FAC6887777, {$urandom, $urandom});
      send_block(10'd0, 10'd0, '0, {$urandom, $urandom});
      send_block(10'd1023, 10'd1023, '1, {$urandom, $urandom});

      // Format code three and a width above the maximum.
      configure(FMT_DXT5_ALIAS, 13'd8191, 13'd4096);
      send_block(10'd1023, 10'd2, 64'hFAC688FAC68840C0, {$urandom, $urandom});
      send_block(10'd1023, 10'd1023, 64'hFAC688FAC688C040, {$urandom, $urandom});

      // Zero height lets nothing through; a one-texel-wide image keeps column zero.
      configure(FMT_DXT1, 13'd4096, 13'd0);
      send_block(10'd0, 10'd0, '0, {$urandom, $urandom});
      configure(FMT_DXT3, 13'd1, 13'd8191);
      send_block(10'd0, 10'd0, {$urandom, $urandom}, {$urandom, $urandom});
      send_block(10'd1023, 10'd0, {$urandom, $urandom}, {$urandom, $urandom});

      random_phase(FMT_DXT1, 13'd4096, 13'd4096, 40);
      random_phase(FMT_DXT3, 13'd37, 13'd22, 40);
      random_phase(FMT_DXT5, 13'd1, 13'd1, 30);

      drain();
      send_idle_pct = 75;
      recv_idle_pct = 31;
      random_phase(FMT_DXT5_ALIAS, 13'd4096, 13'd13, 30);
      random_phase(FMT_DXT1, 13'd8191, 13'd5, 30);
      random_phase(FMT_DXT5, 13'd100, 13'd4096, 40);

      drain();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      random_phase(FMT_DXT3, 13'd3, 13'd4097, 30);
      random_phase(FMT_DXT1, 13'd0, 13'd9, 10);
      random_phase(FMT_DXT5, 13'd64, 13'd64, 50);

      drain();
      $display("Sent %0d block beats and checked %0d texel beats across all format codes,",
               sb.blocks, sb.texels);
      $display("image sizes from zero to above the maximum, and three stall patterns.");
      if (sb.errors == 0 && sb.pending.size() == 0) begin
         $display("dxt_block_texel_decoder test passed");
      end else begin
         $display("%0d bad texel beats, %0d texels never arrived", sb.errors,
                  sb.pending.size());
         $display("dxt_block_texel_decoder test failed");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("Timed out waiting for the block to finish.");
      $display("dxt_block_texel_decoder test failed");
      $finish;
   end

endmodule

// File: dxt_block_texel_decoder.f
rtl/dxt_pkg.sv
rtl/dxt_block_texel_decoder.sv
sim/tb.sv
